/* hw/rtl/ofdm_dpsk_iq_tone_synthesizer_defines.svh */
// ============================================================================
// Assertion macros for the IQ tone synthesizer
// Concurrent check macros that compile to nothing when SYNTH is defined.
// ============================================================================
`ifndef OFDM_DPSK_IQ_TONE_SYNTHESIZER_DEFINES_SVH
`define OFDM_DPSK_IQ_TONE_SYNTHESIZER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge out of reset
`define ODT_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("odt assertion failed");
// Next-cycle implication
`define ODT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("odt assertion failed");
`else
`define ODT_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ODT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

/* hw/rtl/odt_pkg.sv */
// ============================================================================
// odt_pkg
// Shared types and constants of the OFDM DPSK IQ tone synthesizer.
// ============================================================================
package odt_pkg;

    // Default geometry
    localparam int DEF_SYMBOL_LEN      = 192;
    localparam int DEF_BODY_LEN        = 160;
    localparam int DEF_PREFIX_LEN      = 32;
    localparam int DEF_TONE_COUNT      = 4;
    localparam int DEF_SINE_INDEX_BITS = 12;

    // Field widths
    localparam int OP_W           = 3;
    localparam int NIBBLE_W       = 4;
    localparam int SAMPLE_W       = 16;
    localparam int PHASE_W        = 32;
    localparam int MAX_TONE_COUNT = 8;
    localparam int DATA_STEP_COUNT = 4;

    // Configuration registers
    localparam int CFG_COUNT = 6;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int REG_PRE_A  = 0;
    localparam int REG_PRE_B  = 1;
    localparam int REG_DATA0  = 2;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
        32'd0,
        32'd0,
        32'd134217728,
        32'd161061274,
        32'd187904819,
        32'd214748365
    };

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PREAMBLE = 3'd0,
        OP_DATA     = 3'd1,
        OP_LOAD     = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_RESTART  = 3'd4
    } op_t;

    // Control carried alongside each pipeline stage
    typedef struct packed {
        logic                      valid;
        logic                      preamble;
        logic [MAX_TONE_COUNT-1:0] flags;
    } odt_ctl_t;

endpackage

/* hw/rtl/odt_front.sv */
// ============================================================================
// odt_front
// Item intake, sample counter, DPSK flags, configuration registers and the
// per-lane phase multipliers feeding the phase register stage.
// ============================================================================
`include "ofdm_dpsk_iq_tone_synthesizer_defines.svh"

module odt_front
    import odt_pkg::*;
#(
    parameter int SYMBOL_LEN = DEF_SYMBOL_LEN,
    parameter int BODY_LEN   = DEF_BODY_LEN,
    parameter int PREFIX_LEN = DEF_PREFIX_LEN,
    parameter int TONE_COUNT = DEF_TONE_COUNT,
    parameter int LANE_COUNT = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [OP_W-1:0]                     op,
    input  logic [NIBBLE_W-1:0]                 nibble,
    input  logic                                cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_W-1:0]                    cfg_wr_data,
    input  logic                                down_ready,
    output odt_ctl_t                            out_ctl,
    output logic [LANE_COUNT-1:0][PHASE_W-1:0]  phase
);

    localparam int IDX_W = (SYMBOL_LEN > 1) ? $clog2(SYMBOL_LEN) : 1;
    localparam logic [PHASE_W-1:0] BACK = PHASE_W'(BODY_LEN - PREFIX_LEN);

    logic [CFG_W-1:0]                   cfg_reg [CFG_COUNT];
    logic [IDX_W-1:0]                   sample_idx_reg;
    logic [IDX_W-1:0]                   sample_idx_next;
    logic [TONE_COUNT-1:0]              flags_reg;
    logic [TONE_COUNT-1:0]              flags_next;
    odt_ctl_t                           ctl_reg;
    odt_ctl_t                           ctl_next;
    logic [LANE_COUNT-1:0][PHASE_W-1:0] phase_reg;
    logic [LANE_COUNT-1:0][PHASE_W-1:0] phase_next;
    logic [IDX_W:0]                     idx_inc;
    logic [PHASE_W-1:0]                 mult;
    logic                               ready;
    logic                               accept;
    logic                               is_tick;
    logic                               is_pre;

    // Stage handshake
    assign ready    = !ctl_reg.valid || down_ready;
    assign in_stall = !ready;
    assign accept   = in_valid && ready;

    // Decode the item and work out the next counter and flags
    always_comb
    begin
        idx_inc         = {1'b0, sample_idx_reg} + 1'b1;
        sample_idx_next = sample_idx_reg;
        flags_next      = flags_reg;
        is_tick         = 1'b0;
        is_pre          = 1'b0;
        case (op_t'(op))
            OP_PREAMBLE:
            begin
                is_tick = 1'b1;
                is_pre  = 1'b1;
                if (32'(idx_inc) >= 32'(BODY_LEN) || 32'(idx_inc) >= 32'(SYMBOL_LEN))
                    sample_idx_next = '0;
                else
                    sample_idx_next = idx_inc[IDX_W-1:0];
            end
            OP_DATA:
            begin
                is_tick = 1'b1;
                if (32'(idx_inc) >= 32'(SYMBOL_LEN))
                    sample_idx_next = '0;
                else
                    sample_idx_next = idx_inc[IDX_W-1:0];
            end
            OP_LOAD:
            begin
                for (int t = 0; t < TONE_COUNT; t++)
                begin
                    if (t < NIBBLE_W)
                        flags_next[t] = flags_reg[t] ^ nibble[t];
                end
            end
            OP_CLEAR:
            begin
                flags_next = '0;
            end
            OP_RESTART:
            begin
                sample_idx_next = '0;
            end
            default:
            begin
                sample_idx_next = sample_idx_reg;
            end
        endcase
    end

    // Phase multiplier: data ticks take BODY_LEN - PREFIX_LEN back from the sample index
    assign mult = is_pre ? PHASE_W'(sample_idx_reg) : PHASE_W'(sample_idx_reg) - BACK;

    always_comb
    begin
        for (int t = 0; t < LANE_COUNT; t++)
        begin
            if (is_pre)
                phase_next[t] = ((t == 0) ? cfg_reg[REG_PRE_A] : cfg_reg[REG_PRE_B]) * mult;
            else
                phase_next[t] = cfg_reg[REG_DATA0 + (t % DATA_STEP_COUNT)] * mult;
        end
    end

    always_comb
    begin
        ctl_next.valid    = accept && is_tick;
        ctl_next.preamble = is_pre;
        ctl_next.flags    = MAX_TONE_COUNT'(flags_reg);
    end

    // Configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < CFG_COUNT; r++)
                cfg_reg[r] <= CFG_RESET[r];
        end
        else if (cfg_wr_en && cfg_index < CFG_IDX_W'(CFG_COUNT))
        begin
            cfg_reg[cfg_index] <= cfg_wr_data;
        end
    end

    // Counter and flags advance on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_idx_reg <= '0;
            flags_reg      <= '0;
        end
        else if (accept)
        begin
            sample_idx_reg <= sample_idx_next;
            flags_reg      <= flags_next;
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (ready)
            ctl_reg <= ctl_next;
    end

    // Phase words
    always_ff @(posedge clk)
    begin
        if (ready && accept && is_tick)
            phase_reg <= phase_next;
    end

    assign out_ctl = ctl_reg;
    assign phase   = phase_reg;

    `ODT_ASSERT_IMPLIES(a_idx_range, clk, rst_n, 1'b1, 32'(sample_idx_reg) < 32'(SYMBOL_LEN))
    `ODT_ASSERT_NEXT(a_restart_zero, clk, rst_n, accept && op_t'(op) == OP_RESTART, sample_idx_reg == '0)
    `ODT_ASSERT_NEXT(a_clear_flags, clk, rst_n, accept && op_t'(op) == OP_CLEAR, flags_reg == '0)

endmodule

/* hw/rtl/odt_sine_rom.sv */
// ============================================================================
// odt_sine_rom
// Quarter-wave sine magnitude ROM with two registered read ports, giving the
// sine and cosine of one phase word.
// ============================================================================
module odt_sine_rom
    import odt_pkg::*;
#(
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [PHASE_W-1:0]         phase,
    output logic signed [SAMPLE_W-1:0] sin_val,
    output logic signed [SAMPLE_W-1:0] cos_val
);

    localparam int QB     = SINE_INDEX_BITS - 2;
    localparam int QLEN   = 1 << QB;
    localparam int MAG_W  = SAMPLE_W - 1;
    localparam int ADDR_W = QB + 1;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint C1      = 64'sd1686629713;
    localparam longint C3      = -64'sd693598669;
    localparam longint C5      = 64'sd85569306;
    localparam longint C7      = -64'sd5026995;
    localparam longint C9      = 64'sd172270;

    typedef logic [MAG_W-1:0] mag_table_t [QLEN+1];

    // Build the quarter-wave table from the odd degree-nine polynomial
    function automatic mag_table_t build_table();
        mag_table_t tbl;
        longint     u;
        longint     u2;
        longint     p;
        longint     y;
        longint     m;
        for (int r = 0; r <= QLEN; r++)
        begin
            u  = longint'(r) <<< (30 - QB);
            u2 = (u * u) / Q30_ONE;
            p  = C9;
            p  = C7 + (p * u2) / Q30_ONE;
            p  = C5 + (p * u2) / Q30_ONE;
            p  = C3 + (p * u2) / Q30_ONE;
            p  = C1 + (p * u2) / Q30_ONE;
            y  = (p * u) / Q30_ONE;
            if (y < 0)
                y = 0;
            m = (y + 32768) / 65536;
            if (m > 16384)
                m = 16384;
            tbl[r] = MAG_W'(m);
        end
        return tbl;
    endfunction

    localparam mag_table_t SINE_MAG = build_table();

    logic [SINE_INDEX_BITS-1:0] k_sin;
    logic [SINE_INDEX_BITS-1:0] k_cos;
    logic [ADDR_W-1:0]          addr_sin;
    logic [ADDR_W-1:0]          addr_cos;
    logic [MAG_W-1:0]           mag_sin_reg;
    logic [MAG_W-1:0]           mag_cos_reg;
    logic                       neg_sin_reg;
    logic                       neg_cos_reg;

    // Fold the table index into the first quadrant
    assign k_sin = phase[PHASE_W-1 -: SINE_INDEX_BITS];
    assign k_cos = k_sin + SINE_INDEX_BITS'(QLEN);

    assign addr_sin = k_sin[QB] ? ADDR_W'(QLEN) - {1'b0, k_sin[QB-1:0]}
                                : {1'b0, k_sin[QB-1:0]};
    assign addr_cos = k_cos[QB] ? ADDR_W'(QLEN) - {1'b0, k_cos[QB-1:0]}
                                : {1'b0, k_cos[QB-1:0]};

    // Registered reads; the half-turn bit gives the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_sin_reg <= SINE_MAG[addr_sin];
            mag_cos_reg <= SINE_MAG[addr_cos];
            neg_sin_reg <= k_sin[QB+1];
            neg_cos_reg <= k_cos[QB+1];
        end
    end

    assign sin_val = neg_sin_reg ? SAMPLE_W'(0) - SAMPLE_W'(mag_sin_reg) : SAMPLE_W'(mag_sin_reg);
    assign cos_val = neg_cos_reg ? SAMPLE_W'(0) - SAMPLE_W'(mag_cos_reg) : SAMPLE_W'(mag_cos_reg);

endmodule

/* hw/rtl/odt_lookup.sv */
// ============================================================================
// odt_lookup
// Sine lookup stage: one ROM per lane turns each phase word into cosine and
// sine, with the stage control held alongside.
// ============================================================================
`include "ofdm_dpsk_iq_tone_synthesizer_defines.svh"

module odt_lookup
    import odt_pkg::*;
#(
    parameter int LANE_COUNT      = 2,
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  odt_ctl_t                            in_ctl,
    input  logic [LANE_COUNT-1:0][PHASE_W-1:0]  phase,
    input  logic                                down_ready,
    output logic                                ready,
    output odt_ctl_t                            out_ctl,
    output logic [LANE_COUNT-1:0][SAMPLE_W-1:0] sin_lane,
    output logic [LANE_COUNT-1:0][SAMPLE_W-1:0] cos_lane
);

    odt_ctl_t ctl_reg;

    // Stage handshake
    assign ready = !ctl_reg.valid || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (ready)
            ctl_reg <= in_ctl;
    end

    // One ROM per lane
    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        odt_sine_rom #(
            .SINE_INDEX_BITS (SINE_INDEX_BITS)
        ) u_rom (
            .clk     (clk),
            .en      (ready),
            .phase   (phase[g]),
            .sin_val (sin_lane[g]),
            .cos_val (cos_lane[g])
        );
    end

    assign out_ctl = ctl_reg;

    `ODT_ASSERT_IMPLIES(a_stage_source, clk, rst_n, $rose(ctl_reg.valid), $past(in_ctl.valid))

endmodule

/* hw/rtl/odt_mix.sv */
// ============================================================================
// odt_mix
// Tone summing, scaling and saturation into the result register, with the
// output handshake.
// ============================================================================
`include "ofdm_dpsk_iq_tone_synthesizer_defines.svh"

module odt_mix
    import odt_pkg::*;
#(
    parameter int TONE_COUNT = DEF_TONE_COUNT,
    parameter int LANE_COUNT = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  odt_ctl_t                            in_ctl,
    input  logic [LANE_COUNT-1:0][SAMPLE_W-1:0] sin_lane,
    input  logic [LANE_COUNT-1:0][SAMPLE_W-1:0] cos_lane,
    output logic                                ready,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_W-1:0]          i_sample,
    output logic signed [SAMPLE_W-1:0]          q_sample
);

    localparam int SUM_W = SAMPLE_W + $clog2(LANE_COUNT) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (SAMPLE_W - 1));

    logic signed [SUM_W-1:0]    acc_i;
    logic signed [SUM_W-1:0]    acc_q;
    logic signed [SUM_W-1:0]    scl_i;
    logic signed [SUM_W-1:0]    scl_q;
    logic signed [SAMPLE_W-1:0] i_sample_next;
    logic signed [SAMPLE_W-1:0] q_sample_next;
    logic signed [SAMPLE_W-1:0] i_sample_reg;
    logic signed [SAMPLE_W-1:0] q_sample_reg;
    logic                       out_valid_reg;

    // Result register is free or being taken
    assign ready = !out_valid_reg || !out_stall;

    // Sum the lanes: two tones for the preamble, signed tones for data
    always_comb
    begin
        acc_i = '0;
        acc_q = '0;
        if (in_ctl.preamble)
        begin
            acc_i = SUM_W'($signed(cos_lane[0])) + SUM_W'($signed(cos_lane[1]));
            acc_q = SUM_W'($signed(sin_lane[0])) + SUM_W'($signed(sin_lane[1]));
            scl_i = acc_i >>> 1;
            scl_q = acc_q >>> 1;
        end
        else
        begin
            for (int t = 0; t < LANE_COUNT; t++)
            begin
                if (t < TONE_COUNT)
                begin
                    if (in_ctl.flags[t])
                    begin
                        acc_i = acc_i - SUM_W'($signed(cos_lane[t]));
                        acc_q = acc_q - SUM_W'($signed(sin_lane[t]));
                    end
                    else
                    begin
                        acc_i = acc_i + SUM_W'($signed(cos_lane[t]));
                        acc_q = acc_q + SUM_W'($signed(sin_lane[t]));
                    end
                end
            end
            scl_i = acc_i >>> 2;
            scl_q = acc_q >>> 2;
        end
    end

    // Saturate to the sample range
    always_comb
    begin
        if (scl_i > SAT_HI)
            i_sample_next = SAT_HI[SAMPLE_W-1:0];
        else if (scl_i < SAT_LO)
            i_sample_next = SAT_LO[SAMPLE_W-1:0];
        else
            i_sample_next = scl_i[SAMPLE_W-1:0];

        if (scl_q > SAT_HI)
            q_sample_next = SAT_HI[SAMPLE_W-1:0];
        else if (scl_q < SAT_LO)
            q_sample_next = SAT_LO[SAMPLE_W-1:0];
        else
            q_sample_next = scl_q[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready)
            out_valid_reg <= in_ctl.valid;
    end

    // Hold the result item until taken
    always_ff @(posedge clk)
    begin
        if (ready && in_ctl.valid)
        begin
            i_sample_reg <= i_sample_next;
            q_sample_reg <= q_sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign i_sample  = i_sample_reg;
    assign q_sample  = q_sample_reg;

    `ODT_ASSERT_IMPLIES(a_out_source, clk, rst_n, $rose(out_valid_reg), $past(in_ctl.valid))

endmodule

/* hw/rtl/ofdm_dpsk_iq_tone_synthesizer.sv */
// An accepted tick item passes through the phase, sine ROM and result registers in turn.
// One item per cycle unless stalled; stages are phase multiply, sine ROM read, tone sum.
// A sine ROM per lane is built at elaboration and read through two registered ports.
// Reset clears the sample counter, the phase flags and all stage valids, and loads the
// step registers with their defaults; there is no clearing pass.
// ============================================================================
// ofdm_dpsk_iq_tone_synthesizer
// OFDM DPSK baseband transmitter: one complex IQ sample per preamble or data tick.
// ============================================================================
module ofdm_dpsk_iq_tone_synthesizer
    import odt_pkg::*;
#(
    parameter int SYMBOL_LEN      = DEF_SYMBOL_LEN,
    parameter int BODY_LEN        = DEF_BODY_LEN,
    parameter int PREFIX_LEN      = DEF_PREFIX_LEN,
    parameter int TONE_COUNT      = DEF_TONE_COUNT,
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            op,
    input  logic [NIBBLE_W-1:0]        nibble,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] q_sample,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wr_data
);

    // The preamble always needs two lanes
    localparam int LANE_COUNT = (TONE_COUNT > 2) ? TONE_COUNT : 2;

    odt_ctl_t                            phase_ctl;
    odt_ctl_t                            lookup_ctl;
    logic [LANE_COUNT-1:0][PHASE_W-1:0]  phase;
    logic [LANE_COUNT-1:0][SAMPLE_W-1:0] sin_lane;
    logic [LANE_COUNT-1:0][SAMPLE_W-1:0] cos_lane;
    logic                                lookup_ready;
    logic                                mix_ready;

    odt_front #(
        .SYMBOL_LEN (SYMBOL_LEN),
        .BODY_LEN   (BODY_LEN),
        .PREFIX_LEN (PREFIX_LEN),
        .TONE_COUNT (TONE_COUNT),
        .LANE_COUNT (LANE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .nibble      (nibble),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .down_ready  (lookup_ready),
        .out_ctl     (phase_ctl),
        .phase       (phase)
    );

    odt_lookup #(
        .LANE_COUNT      (LANE_COUNT),
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_lookup (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (phase_ctl),
        .phase      (phase),
        .down_ready (mix_ready),
        .ready      (lookup_ready),
        .out_ctl    (lookup_ctl),
        .sin_lane   (sin_lane),
        .cos_lane   (cos_lane)
    );

    odt_mix #(
        .TONE_COUNT (TONE_COUNT),
        .LANE_COUNT (LANE_COUNT)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (lookup_ctl),
        .sin_lane  (sin_lane),
        .cos_lane  (cos_lane),
        .ready     (mix_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .i_sample  (i_sample),
        .q_sample  (q_sample)
    );

endmodule
